// ===== rtl/core/priority_event_dispatcher_top_macros.svh =====
// ----------------------------------------------------------------------------
// Dispatcher assertion macros
// Concurrent assertion shorthands shared by the dispatcher RTL.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_EVENT_DISPATCHER_TOP_MACROS_SVH
`define PRIORITY_EVENT_DISPATCHER_TOP_MACROS_SVH

// condition holds at every edge out of reset
`define PED_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PED_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define PED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ped_pkg.sv =====
// ----------------------------------------------------------------------------
// Dispatcher package
// Widths, codes, defaults and sequencer states of the event dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ped_pkg;

   localparam int ENTRIES              = 8;
   localparam int ENTRY_LIMIT          = (ENTRIES < 8) ? ENTRIES : 8;
   localparam int DEF_PRIORITY_LEVELS  = 8;
   localparam int DEF_POOL_SLOTS       = 16;

   localparam int MODE_W      = 2;
   localparam int TASK_W      = 3;
   localparam int CTX_W       = 32;
   localparam int STATUS_W    = 2;
   localparam int KIND_W      = 2;
   localparam int COUNT_W     = 4;
   localparam int PRIO_MAP_W  = 24;
   localparam int PRIO_FLD_W  = 3;
   localparam int MASK_W      = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [MODE_W-1:0] {
      MODE_POST    = 2'd0,
      MODE_PROCESS = 2'd1,
      MODE_START   = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NO_DEVICE = 2'd1,
      ST_NO_ENTRY  = 2'd2,
      ST_NO_SPACE  = 2'd3
   } status_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE   = 2'd0,
      KIND_QUEUED = 2'd1,
      KIND_POLL   = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ACTIVE_ENTRIES    = 3'd0,
      CSR_PRIORITY_OF_ENTRY = 3'd1,
      CSR_POLL_MASK         = 3'd2,
      CSR_INIT_MASK         = 3'd3,
      CSR_INIT_CONTEXT      = 3'd4,
      CSR_POLL_CONTEXT      = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POST,
      S_POST_WRITE,
      S_PROC,
      S_PROC_USE,
      S_POLL,
      S_START_WALK,
      S_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/ped_req_if.sv =====
// ----------------------------------------------------------------------------
// Dispatcher request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ped_req_if;
   import ped_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [TASK_W-1:0] target_task;
   logic [CTX_W-1:0]  event_context;

   modport source (output valid, mode, target_task, event_context, input ready);
   modport sink   (input valid, mode, target_task, event_context, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ped_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Dispatcher response channel
// Valid/ready channel carrying one response word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ped_rsp_if;
   import ped_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [KIND_W-1:0]   dispatch_kind;
   logic [TASK_W-1:0]   run_task;
   logic [CTX_W-1:0]    run_context;

   modport source (output valid, status, dispatch_kind, run_task, run_context, input ready);
   modport sink   (input valid, status, dispatch_kind, run_task, run_context, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/priority_event_dispatcher_top.sv =====
// ----------------------------------------------------------------------------
// Priority event dispatcher
// Strict priority event FIFOs over a shared slot pool, with a round-robin
// poll fallback, run by a small sequencer.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_port  in         valid/ready          mode, target_task, event_context
//  rsp_port  out        valid/ready          status, dispatch_kind, run_task,
//                                            run_context
//  csr_*     in         write enable only    index, write data
//
//  Sequencer paths, all ending in S_FINISH: post S_POST, S_POST_WRITE (S_POST
//  alone when refused); process S_PROC alone with no device, else S_PROC_USE
//  for a queued event or S_POLL over at most the entry count; start
//  S_START_WALK over the entries plus a post per init event; unused mode
//  S_FINISH alone. The sequencer steps one entry, one slot access or one pool
//  operation a cycle; slot, link and free-slot stores are single-read-port
//  RAMs. Reset is synchronous; the pool needs no clearing pass.
//  One response word is held in the output register, so the next request is
//  taken while it waits; the sequencer holds its finished result meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
`include "priority_event_dispatcher_top_macros.svh"

module priority_event_dispatcher_top #(
   parameter int PRIORITY_LEVELS = ped_pkg::DEF_PRIORITY_LEVELS,
   parameter int POOL_SLOTS      = ped_pkg::DEF_POOL_SLOTS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   ped_req_if.sink                                 req_port,
   ped_rsp_if.source                               rsp_port,
   input  wire logic                               csr_write_enable,
   input  wire logic [ped_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [ped_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import ped_pkg::*;

   localparam int SLOT_W = $clog2(POOL_SLOTS);
   localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
   localparam int PRIO_W = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
   localparam int DATA_W = TASK_W + CTX_W;

   function automatic logic [TASK_W-1:0] mod_small(input logic [TASK_W-1:0]  value,
                                                   input logic [COUNT_W-1:0] modulus);
      logic [COUNT_W-1:0] rem;
      rem = COUNT_W'(value);
      for (int k = 0; k < (1 << TASK_W) - 1; k++) begin
         if (rem >= modulus) begin
            rem = rem - modulus;
         end
      end
      return rem[TASK_W-1:0];
   endfunction

   // configuration
   logic [COUNT_W-1:0]    active_entries_ff;
   logic [PRIO_MAP_W-1:0] priority_map_ff;
   logic [MASK_W-1:0]     poll_mask_ff;
   logic [MASK_W-1:0]     init_mask_ff;
   logic [CTX_W-1:0]      init_context_ff;
   logic [CTX_W-1:0]      poll_context_ff;

   // sequencer
   state_type             state_ff, state_in;
   logic                  start_ff, start_in;
   logic [TASK_W-1:0]     post_task_ff, post_task_in;
   logic [CTX_W-1:0]      post_ctx_ff, post_ctx_in;
   logic [PRIO_W-1:0]     post_prio_ff, post_prio_in;
   logic                  pop_ff, pop_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [COUNT_W-1:0]    walk_ff, walk_in;
   logic [TASK_W-1:0]     poll_idx_ff, poll_idx_in;
   logic [TASK_W-1:0]     poll_cnt_ff, poll_cnt_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [KIND_W-1:0]     res_kind_ff, res_kind_in;
   logic [TASK_W-1:0]     res_task_ff, res_task_in;
   logic [CTX_W-1:0]      res_ctx_ff, res_ctx_in;

   // queues and pool
   logic [PRIORITY_LEVELS-1:0] occ_ff, occ_in;
   logic [SLOT_W-1:0]          queue_first_ff [PRIORITY_LEVELS];
   logic [SLOT_W-1:0]          queue_last_ff  [PRIORITY_LEVELS];
   logic [CNT_W-1:0]           bump_ff, bump_in;
   logic [CNT_W-1:0]           sc_ff, sc_in;
   logic [TASK_W-1:0]          cursor_ff, cursor_in;

   // response register
   logic                  out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]   out_status_ff;
   logic [KIND_W-1:0]     out_kind_ff;
   logic [TASK_W-1:0]     out_task_ff;
   logic [CTX_W-1:0]      out_ctx_ff;

   // strobes and datapath
   logic                  out_load;
   logic                  data_we, link_we, stack_we, first_we, last_we;
   logic [PRIO_W-1:0]     q_prio;
   logic [SLOT_W-1:0]     q_slot;
   logic [SLOT_W-1:0]     post_slot;
   logic [SLOT_W-1:0]     head_slot;
   logic [PRIO_W-1:0]     head_prio;
   logic                  any_occ;
   logic [COUNT_W-1:0]    live_count;
   logic [COUNT_W-1:0]    entry_last;
   logic [PRIO_FLD_W-1:0] post_prio_fld;
   logic [3:0]            post_prio_ext;
   logic [COUNT_W-1:0]    poll_inc;
   logic [TASK_W-1:0]     poll_next;
   logic [CNT_W-1:0]      sc_dec;
   logic [DATA_W-1:0]     data_rdata;
   logic [SLOT_W-1:0]     link_rdata;
   logic [SLOT_W-1:0]     stack_rdata;
   logic [TASK_W-1:0]     head_task;
   logic [CTX_W-1:0]      head_ctx;

   assign live_count    = (active_entries_ff > COUNT_W'(ENTRY_LIMIT)) ?
                          COUNT_W'(ENTRY_LIMIT) : active_entries_ff;
   assign entry_last    = live_count - COUNT_W'(1);
   assign post_prio_fld = priority_map_ff[PRIO_FLD_W*post_task_ff +: PRIO_FLD_W];
   assign post_prio_ext = {1'b0, post_prio_fld};
   assign poll_inc      = {1'b0, poll_idx_ff} + COUNT_W'(1);
   assign poll_next     = (poll_inc == live_count) ? '0 : poll_inc[TASK_W-1:0];
   assign sc_dec        = sc_ff - CNT_W'(1);
   assign any_occ       = |occ_ff;
   assign head_slot     = queue_first_ff[head_prio];
   assign post_slot     = pop_ff ? stack_rdata : slot_ff;
   assign head_task     = data_rdata[DATA_W-1:CTX_W];
   assign head_ctx      = data_rdata[CTX_W-1:0];

   always_comb begin
      head_prio = '0;
      for (int p = PRIORITY_LEVELS - 1; p >= 0; p--) begin
         if (occ_ff[p]) begin
            head_prio = PRIO_W'(p);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      start_in      = start_ff;
      post_task_in  = post_task_ff;
      post_ctx_in   = post_ctx_ff;
      post_prio_in  = post_prio_ff;
      pop_in        = pop_ff;
      slot_in       = slot_ff;
      walk_in       = walk_ff;
      poll_idx_in   = poll_idx_ff;
      poll_cnt_in   = poll_cnt_ff;
      res_status_in = res_status_ff;
      res_kind_in   = res_kind_ff;
      res_task_in   = res_task_ff;
      res_ctx_in    = res_ctx_ff;
      occ_in        = occ_ff;
      bump_in       = bump_ff;
      sc_in         = sc_ff;
      cursor_in     = cursor_ff;
      out_load      = 1'b0;
      data_we       = 1'b0;
      link_we       = 1'b0;
      stack_we      = 1'b0;
      first_we      = 1'b0;
      last_we       = 1'b0;
      q_prio        = post_prio_ff;
      q_slot        = post_slot;

      case (state_ff)
         S_IDLE: begin
            if (req_port.valid) begin
               res_status_in = ST_OK;
               res_kind_in   = KIND_NONE;
               res_task_in   = '0;
               res_ctx_in    = '0;
               start_in      = 1'b0;
               post_task_in  = req_port.target_task;
               post_ctx_in   = req_port.event_context;
               if (req_port.mode == MODE_POST) begin
                  state_in = S_POST;
               end else if (req_port.mode == MODE_PROCESS) begin
                  state_in = S_PROC;
               end else if (req_port.mode == MODE_START) begin
                  occ_in    = '0;
                  bump_in   = '0;
                  sc_in     = '0;
                  cursor_in = '0;
                  walk_in   = '0;
                  start_in  = 1'b1;
                  state_in  = S_START_WALK;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_POST: begin
            post_prio_in = post_prio_ext[PRIO_W-1:0];
            if (live_count == '0) begin
               res_status_in = ST_NO_DEVICE;
               state_in      = S_FINISH;
            end else if (COUNT_W'(post_task_ff) >= live_count) begin
               res_status_in = ST_NO_ENTRY;
               state_in      = S_FINISH;
            end else if (5'(post_prio_ext) >= 5'(PRIORITY_LEVELS)) begin
               res_status_in = ST_NO_ENTRY;
               state_in      = S_FINISH;
            end else if (sc_ff == '0 && bump_ff == CNT_W'(POOL_SLOTS)) begin
               res_status_in = ST_NO_SPACE;
               state_in      = S_FINISH;
            end else if (sc_ff != '0) begin
               pop_in   = 1'b1;
               sc_in    = sc_dec;
               state_in = S_POST_WRITE;
            end else begin
               pop_in   = 1'b0;
               slot_in  = bump_ff[SLOT_W-1:0];
               bump_in  = bump_ff + CNT_W'(1);
               state_in = S_POST_WRITE;
            end
         end
         S_POST_WRITE: begin
            data_we = 1'b1;
            last_we = 1'b1;
            if (occ_ff[post_prio_ff]) begin
               link_we = 1'b1;
            end else begin
               first_we             = 1'b1;
               occ_in[post_prio_ff] = 1'b1;
            end
            if (start_ff) begin
               walk_in  = walk_ff + COUNT_W'(1);
               state_in = S_START_WALK;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_PROC: begin
            if (live_count == '0) begin
               state_in = S_FINISH;
            end else if (any_occ) begin
               state_in = S_PROC_USE;
            end else begin
               poll_idx_in = mod_small(cursor_ff, live_count);
               poll_cnt_in = '0;
               state_in    = S_POLL;
            end
         end
         S_PROC_USE: begin
            q_prio = head_prio;
            q_slot = link_rdata;
            if (queue_last_ff[head_prio] == head_slot) begin
               occ_in[head_prio] = 1'b0;
            end else begin
               first_we = 1'b1;
            end
            stack_we = 1'b1;
            sc_in    = sc_ff + CNT_W'(1);
            if (COUNT_W'(head_task) < live_count) begin
               res_kind_in = KIND_QUEUED;
               res_task_in = head_task;
               res_ctx_in  = head_ctx;
            end
            state_in = S_FINISH;
         end
         S_POLL: begin
            if (poll_mask_ff[poll_idx_ff]) begin
               res_kind_in = KIND_POLL;
               res_task_in = poll_idx_ff;
               res_ctx_in  = poll_context_ff;
               cursor_in   = poll_next;
               state_in    = S_FINISH;
            end else if (COUNT_W'(poll_cnt_ff) == entry_last) begin
               state_in = S_FINISH;
            end else begin
               poll_cnt_in = poll_cnt_ff + TASK_W'(1);
               poll_idx_in = poll_next;
            end
         end
         S_START_WALK: begin
            if (walk_ff >= live_count) begin
               state_in = S_FINISH;
            end else if (init_mask_ff[walk_ff[TASK_W-1:0]]) begin
               post_task_in = walk_ff[TASK_W-1:0];
               post_ctx_in  = init_context_ff;
               state_in     = S_POST;
            end else begin
               walk_in = walk_ff + COUNT_W'(1);
            end
         end
         S_FINISH: begin
            if (!out_valid_ff || rsp_port.ready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_entries_ff <= '0;
         priority_map_ff   <= '0;
         poll_mask_ff      <= '0;
         init_mask_ff      <= '0;
         init_context_ff   <= '0;
         poll_context_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ACTIVE_ENTRIES:    active_entries_ff <= csr_write_data[COUNT_W-1:0];
            CSR_PRIORITY_OF_ENTRY: priority_map_ff   <= csr_write_data[PRIO_MAP_W-1:0];
            CSR_POLL_MASK:         poll_mask_ff      <= csr_write_data[MASK_W-1:0];
            CSR_INIT_MASK:         init_mask_ff      <= csr_write_data[MASK_W-1:0];
            CSR_INIT_CONTEXT:      init_context_ff   <= csr_write_data[CTX_W-1:0];
            CSR_POLL_CONTEXT:      poll_context_ff   <= csr_write_data[CTX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         occ_ff       <= '0;
         bump_ff      <= '0;
         sc_ff        <= '0;
         cursor_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         occ_ff       <= occ_in;
         bump_ff      <= bump_in;
         sc_ff        <= sc_in;
         cursor_ff    <= cursor_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      post_task_ff  <= post_task_in;
      post_ctx_ff   <= post_ctx_in;
      post_prio_ff  <= post_prio_in;
      pop_ff        <= pop_in;
      slot_ff       <= slot_in;
      walk_ff       <= walk_in;
      poll_idx_ff   <= poll_idx_in;
      poll_cnt_ff   <= poll_cnt_in;
      res_status_ff <= res_status_in;
      res_kind_ff   <= res_kind_in;
      res_task_ff   <= res_task_in;
      res_ctx_ff    <= res_ctx_in;
      if (out_load) begin
         out_status_ff <= res_status_ff;
         out_kind_ff   <= res_kind_ff;
         out_task_ff   <= res_task_ff;
         out_ctx_ff    <= res_ctx_ff;
      end
      if (first_we) begin
         queue_first_ff[q_prio] <= q_slot;
      end
      if (last_we) begin
         queue_last_ff[q_prio] <= q_slot;
      end
   end

   ped_ram #(
      .WIDTH (DATA_W),
      .DEPTH (POOL_SLOTS)
   ) u_slot_data (
      .clock        (clock),
      .write_enable (data_we),
      .write_addr   (post_slot),
      .write_data   ({post_task_ff, post_ctx_ff}),
      .read_addr    (head_slot),
      .read_data    (data_rdata)
   );

   ped_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (POOL_SLOTS)
   ) u_slot_link (
      .clock        (clock),
      .write_enable (link_we),
      .write_addr   (queue_last_ff[post_prio_ff]),
      .write_data   (post_slot),
      .read_addr    (head_slot),
      .read_data    (link_rdata)
   );

   ped_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (POOL_SLOTS)
   ) u_free_stack (
      .clock        (clock),
      .write_enable (stack_we),
      .write_addr   (sc_ff[SLOT_W-1:0]),
      .write_data   (head_slot),
      .read_addr    (sc_dec[SLOT_W-1:0]),
      .read_data    (stack_rdata)
   );

   assign req_port.ready         = (state_ff == S_IDLE) && !reset;
   assign rsp_port.valid         = out_valid_ff;
   assign rsp_port.status        = out_status_ff;
   assign rsp_port.dispatch_kind = out_kind_ff;
   assign rsp_port.run_task      = out_task_ff;
   assign rsp_port.run_context   = out_ctx_ff;

   `PED_ASSERT_ALWAYS(a_pool_count, clock, reset, sc_ff <= bump_ff, "free stack deeper than pool")
   `PED_ASSERT_NEXT(a_leave_idle, clock, reset, req_port.valid && req_port.ready, !req_port.ready, "ready after accept")
   `PED_ASSERT_IMPLY(a_poll_device, clock, reset, state_ff == S_POLL, live_count != '0, "poll without device")
   `PED_ASSERT_IMPLY(a_pop_occupied, clock, reset, state_ff == S_PROC_USE, any_occ, "dequeue from empty queues")

endmodule

`default_nettype wire

// ===== rtl/core/ped_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ped_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              write_enable,
   input  wire logic [ADDR_W-1:0] write_addr,
   input  wire logic [WIDTH-1:0]  write_data,
   input  wire logic [ADDR_W-1:0] read_addr,
   output logic      [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      rdata_ff <= mem_ff[read_addr];
   end

   assign read_data = rdata_ff;

endmodule

`default_nettype wire

// ===== tb/tb_priority_event_dispatcher_top.sv =====
// ----------------------------------------------------------------------------
// Priority event dispatcher testbench
// Drives post, process, start and unused-mode requests through the request
// channel and predicts every response word with a cycle-free model of the
// priority FIFOs, the shared slot pool and the round-robin poll. Responses are
// checked in order, field by field. Both channels stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_priority_event_dispatcher_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ped_pkg::*;

   localparam int LEVELS      = DEF_PRIORITY_LEVELS;
   localparam int SLOTS       = DEF_POOL_SLOTS;
   localparam int STALL_LIMIT = 4000;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      status_type          status;
      kind_type            dispatch_kind;
      logic [TASK_W-1:0]   run_task;
      logic [CTX_W-1:0]    run_context;
   } dispatch_word_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   ped_req_if req_bus ();
   ped_rsp_if rsp_bus ();

   priority_event_dispatcher_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_bus),
      .rsp_port         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // register copies and scheduler state
   logic [COUNT_W-1:0]    cfg_active;
   logic [PRIO_MAP_W-1:0] cfg_prio_map;
   logic [MASK_W-1:0]     cfg_poll_mask;
   logic [MASK_W-1:0]     cfg_init_mask;
   logic [CTX_W-1:0]      cfg_init_ctx;
   logic [CTX_W-1:0]      cfg_poll_ctx;

   int              pool_task [SLOTS];
   logic [CTX_W-1:0] pool_ctx [SLOTS];
   int              pool_link [SLOTS];
   bit              pool_busy [SLOTS];
   int              fifo_head [LEVELS];
   int              fifo_tail [LEVELS];
   bit              fifo_live [LEVELS];
   int              poll_ptr;

   dispatch_word_type pending_words [$];
   bit steady = 1'b0;
   int mismatches = 0;
   int words_checked = 0;
   int settings_used = 0;
   int mode_count [4] = '{0, 0, 0, 0};
   int queued_seen = 0, polls_seen = 0, idle_seen = 0, full_seen = 0;

   function automatic int live_entries();
      int n;
      n = int'(cfg_active);
      if (n > ENTRY_LIMIT) n = ENTRY_LIMIT;
      return n;
   endfunction

   function automatic void clear_fifos();
      for (int s = 0; s < SLOTS; s++) pool_busy[s] = 1'b0;
      for (int l = 0; l < LEVELS; l++) fifo_live[l] = 1'b0;
      poll_ptr = 0;
   endfunction

   function automatic status_type enqueue(int tgt, logic [CTX_W-1:0] ctx);
      int n;
      int lvl;
      int s;
      n = live_entries();
      if (n == 0) return ST_NO_DEVICE;
      if (tgt >= n) return ST_NO_ENTRY;
      lvl = int'(cfg_prio_map[3*tgt +: PRIO_FLD_W]);
      if (lvl >= LEVELS) return ST_NO_ENTRY;
      s = SLOTS;
      for (int k = SLOTS - 1; k >= 0; k--) if (!pool_busy[k]) s = k;
      if (s >= SLOTS) return ST_NO_SPACE;
      pool_busy[s] = 1'b1;
      pool_task[s] = tgt;
      pool_ctx[s]  = ctx;
      pool_link[s] = 0;
      if (fifo_live[lvl]) begin
         pool_link[fifo_tail[lvl]] = s;
      end else begin
         fifo_head[lvl] = s;
         fifo_live[lvl] = 1'b1;
      end
      fifo_tail[lvl] = s;
      return ST_OK;
   endfunction

   function automatic dispatch_word_type model_word(logic [MODE_W-1:0] mode,
                                                    logic [TASK_W-1:0] tgt,
                                                    logic [CTX_W-1:0] ctx);
      dispatch_word_type w;
      int n;
      int s;
      int idx;
      bit done;
      w = '0;
      n = live_entries();
      done = 1'b0;
      case (mode)
         MODE_POST: w.status = enqueue(int'(tgt), ctx);
         MODE_PROCESS: begin
            if (n != 0) begin
               for (int l = 0; l < LEVELS; l++) begin
                  if (fifo_live[l] && !done) begin
                     s = fifo_head[l];
                     if (fifo_tail[l] == s) fifo_live[l] = 1'b0;
                     else fifo_head[l] = pool_link[s];
                     pool_busy[s] = 1'b0;
                     if (pool_task[s] < n) begin
                        w.dispatch_kind = KIND_QUEUED;
                        w.run_task      = TASK_W'(pool_task[s]);
                        w.run_context   = pool_ctx[s];
                     end
                     done = 1'b1;
                  end
               end
               for (int i = 0; i < n; i++) begin
                  idx = (poll_ptr + i) % n;
                  if (!done && cfg_poll_mask[idx]) begin
                     w.dispatch_kind = KIND_POLL;
                     w.run_task      = TASK_W'(idx);
                     w.run_context   = cfg_poll_ctx;
                     poll_ptr = (idx + 1) % n;
                     done = 1'b1;
                  end
               end
            end
         end
         MODE_START: begin
            clear_fifos();
            for (int i = 0; i < n; i++) begin
               if (cfg_init_mask[i] && w.status == ST_OK) w.status = enqueue(i, cfg_init_ctx);
            end
         end
         default: ;
      endcase
      return w;
   endfunction

   task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatches++;
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   task automatic send_word(logic [MODE_W-1:0] mode, logic [TASK_W-1:0] tgt,
                            logic [CTX_W-1:0] ctx);
      int gap;
      gap = 0;
      if (!steady) while ($urandom_range(0, 99) < 7) gap++;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.mode          <= mode;
      req_bus.target_task   <= tgt;
      req_bus.event_context <= ctx;
      do @(posedge clock); while (!req_bus.ready);
      pending_words.push_back(model_word(mode, tgt, ctx));
      mode_count[mode]++;
   endtask

   task automatic drain_words();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_words.size() != 0);
   endtask

   task automatic put_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
   endtask

   // upper bits beyond each register's width carry noise
   task automatic set_config(logic [COUNT_W-1:0] active, logic [PRIO_MAP_W-1:0] map,
                             logic [MASK_W-1:0] poll, logic [MASK_W-1:0] init,
                             logic [CTX_W-1:0] init_ctx, logic [CTX_W-1:0] poll_ctx);
      drain_words();
      repeat (4) @(posedge clock);
      cfg_active    = active;
      cfg_prio_map  = map;
      cfg_poll_mask = poll;
      cfg_init_mask = init;
      cfg_init_ctx  = init_ctx;
      cfg_poll_ctx  = poll_ctx;
      put_reg(CSR_ACTIVE_ENTRIES,    {$urandom} & ~32'hF | 32'(active));
      put_reg(CSR_PRIORITY_OF_ENTRY, {$urandom} & ~32'hFF_FFFF | 32'(map));
      put_reg(CSR_POLL_MASK,         {$urandom} & ~32'hFF | 32'(poll));
      put_reg(CSR_INIT_MASK,         {$urandom} & ~32'hFF | 32'(init));
      put_reg(CSR_INIT_CONTEXT,      init_ctx);
      put_reg(CSR_POLL_CONTEXT,      poll_ctx);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 7);
   end

   always @(posedge clock) begin : check_words
      dispatch_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_words.size() == 0) begin
            flag_mismatch("word with nothing pending", rsp_bus.status, 0);
         end else begin
            want = pending_words.pop_front();
            words_checked++;
            if (rsp_bus.status !== want.status)
               flag_mismatch("status", rsp_bus.status, want.status);
            if (rsp_bus.dispatch_kind !== want.dispatch_kind)
               flag_mismatch("dispatch_kind", rsp_bus.dispatch_kind, want.dispatch_kind);
            if (rsp_bus.run_task !== want.run_task)
               flag_mismatch("run_task", rsp_bus.run_task, want.run_task);
            if (rsp_bus.run_context !== want.run_context)
               flag_mismatch("run_context", rsp_bus.run_context, want.run_context);
            case (want.dispatch_kind)
               KIND_QUEUED: queued_seen++;
               KIND_POLL:   polls_seen++;
               default:     idle_seen++;
            endcase
            if (want.status == ST_NO_SPACE) full_seen++;
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("priority_event_dispatcher_top regression: fail");
      $finish;
   end

   task automatic test_no_device();
      send_word(MODE_POST, 3'd0, 32'h1234_5678);
      send_word(MODE_PROCESS, 3'd7, 32'h0);
      send_word(MODE_START, 3'd0, 32'hFFFF_FFFF);
      send_word(MODE_UNUSED, 3'd7, 32'hFFFF_FFFF);
   endtask

   task automatic test_priority_order();
      // entry 1 most urgent, entries 0 and 2 share level 2
      set_config(4'd3, 24'h000082, 8'h00, 8'h00, 32'h0, 32'h0);
      send_word(MODE_POST, 3'd5, $urandom);
      send_word(MODE_POST, 3'd0, 32'h0000_0000);
      send_word(MODE_POST, 3'd2, 32'hFFFF_FFFF);
      send_word(MODE_POST, 3'd1, $urandom);
      repeat (4) send_word(MODE_PROCESS, 3'($urandom), $urandom);
   endtask

   task automatic test_pool_limit();
      set_config(4'd15, 24'($urandom), 8'h00, 8'hFF, 32'hFFFF_FFFF, 32'h0);
      send_word(MODE_START, 3'd0, 32'h0);
      repeat (9) send_word(MODE_POST, 3'($urandom), $urandom);
   endtask

   task automatic test_stale_and_poll_wrap();
      set_config(4'd8, 24'($urandom), 8'h22, 8'h00, 32'h0, 32'hA5A5_5A5A);
      send_word(MODE_START, 3'd0, 32'h0);
      send_word(MODE_PROCESS, 3'd0, 32'h0);
      send_word(MODE_PROCESS, 3'd0, 32'h0);
      send_word(MODE_POST, 3'd6, $urandom);
      // shrink the entry count: queued entry 6 goes stale, cursor 6 wraps
      set_config(4'd4, cfg_prio_map, 8'h22, 8'h00, 32'h0, 32'hA5A5_5A5A);
      send_word(MODE_PROCESS, 3'd0, 32'h0);
      send_word(MODE_PROCESS, 3'd0, 32'h0);
   endtask

   task automatic test_random_traffic();
      int n;
      int r;
      logic [MODE_W-1:0] mode;
      logic [TASK_W-1:0] tgt;
      logic [CTX_W-1:0]  ctx;
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: set_config(4'd8, 24'h000000, 8'hFF, 8'hFF, 32'h0, 32'hFFFF_FFFF);
            1: set_config(4'd15, 24'hFF_FFFF, 8'h00, 8'h00, 32'hFFFF_FFFF, 32'h0);
            2: set_config(4'd1, 24'($urandom), 8'h01, 8'h01, $urandom, $urandom);
            3: set_config(4'd0, 24'($urandom), 8'($urandom), 8'($urandom), $urandom, $urandom);
            default: set_config(4'($urandom_range(1, 15)), 24'($urandom), 8'($urandom),
                                8'($urandom), $urandom, $urandom);
         endcase
         steady = (phase == 5);
         for (int k = 0; k < ((phase == 3) ? 30 : 70); k++) begin
            if (k == 35) drain_words();
            n = live_entries();
            r = $urandom_range(0, 99);
            if (r < 48) mode = MODE_POST;
            else if (r < 88) mode = MODE_PROCESS;
            else if (r < 95) mode = MODE_START;
            else mode = MODE_UNUSED;
            if (n > 0 && $urandom_range(0, 4) != 0) tgt = 3'($urandom_range(0, n - 1));
            else tgt = 3'($urandom_range(0, 7));
            r = $urandom_range(0, 9);
            if (r == 0) ctx = 32'h0;
            else if (r == 1) ctx = 32'hFFFF_FFFF;
            else ctx = $urandom;
            send_word(mode, tgt, ctx);
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.mode          <= MODE_POST;
      req_bus.target_task   <= '0;
      req_bus.event_context <= '0;
      csr_write_enable      <= 1'b0;
      csr_index             <= CSR_ACTIVE_ENTRIES;
      csr_write_data        <= '0;
      cfg_active    = '0;
      cfg_prio_map  = '0;
      cfg_poll_mask = '0;
      cfg_init_mask = '0;
      cfg_init_ctx  = '0;
      cfg_poll_ctx  = '0;
      clear_fifos();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_no_device();
      test_priority_order();
      test_pool_limit();
      test_stale_and_poll_wrap();
      test_random_traffic();

      drain_words();
      repeat (40) @(posedge clock);
      if (pending_words.size() != 0)
         flag_mismatch("words never returned", pending_words.size(), 0);
      $display("covered %0d requests (post %0d, process %0d, start %0d, unused %0d) over %0d settings",
               mode_count[0] + mode_count[1] + mode_count[2] + mode_count[3],
               mode_count[0], mode_count[1], mode_count[2], mode_count[3], settings_used);
      $display("checked %0d words: %0d queued, %0d polled, %0d idle, %0d full-pool refusals",
               words_checked, queued_seen, polls_seen, idle_seen, full_seen);
      if (mismatches == 0) begin
         $display("priority_event_dispatcher_top regression: pass");
      end else begin
         $display("priority_event_dispatcher_top regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
